[hw/rtl/mrtp_pkg.sv]
// mrtp_pkg: shared types and constants for the multi-rate tick pending counters.
// No dependencies; every other file imports this package.
package mrtp_pkg;

	localparam int NUM_DIVIDERS   = 9;
	localparam int NUM_PENDING    = 10;
	localparam int DIV_WIDTH      = 10;
	localparam int SEL_WIDTH      = 4;
	localparam int RESULT_WIDTH   = 8;
	localparam int LIMIT_WIDTH    = 8;
	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;

	typedef logic [DIV_WIDTH-1:0] div_cnt_t;

	// 2, 5, 10, 20, 50, 100, 200, 500 and 1000 ms dividers
	localparam div_cnt_t DIV_PERIOD [NUM_DIVIDERS] = '{
		10'd2, 10'd5, 10'd10, 10'd20, 10'd50, 10'd100, 10'd200, 10'd500, 10'd1000
	};
	// phase offsets so that the slow rates do not all fire together
	localparam div_cnt_t DIV_START [NUM_DIVIDERS] = '{
		10'd0, 10'd3, 10'd7, 10'd11, 10'd37, 10'd83, 10'd121, 10'd357, 10'd777
	};

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_CONSUME = 1'b1
	} opcode_t;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_PENDING_LIMIT = 1'b0,
		REG_UNMAPPED      = 1'b1
	} reg_idx_t;

	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 8'd255;

	// one accepted word, decoded
	typedef struct packed {
		logic                 tick;
		logic                 consume;
		logic [SEL_WIDTH-1:0] sel;
	} mrtp_cmd_t;

endpackage

[hw/rtl/mrtp_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on mrtp_pkg.
interface mrtp_req_if import mrtp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [SEL_WIDTH-1:0] period_select;

	modport source (output valid, output opcode, output period_select, input ready);
	modport sink   (input valid, input opcode, input period_select, output ready);
endinterface

interface mrtp_rsp_if import mrtp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    granted;
	logic [RESULT_WIDTH-1:0] pending_after;

	modport source (output valid, output granted, output pending_after, input ready);
	modport sink   (input valid, input granted, input pending_after, output ready);
endinterface

[hw/rtl/mrtp_divider_bank.sv]
// mrtp_divider_bank: nine phase-offset millisecond dividers.
// Depends on mrtp_pkg; flags a wrap for each divider on the tick that wraps it.
module mrtp_divider_bank import mrtp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick,
	output logic [NUM_DIVIDERS-1:0] wrap
);

	div_cnt_t cnt_q  [NUM_DIVIDERS];
	div_cnt_t cnt_d  [NUM_DIVIDERS];
	div_cnt_t cnt_p1 [NUM_DIVIDERS];

	always_comb begin
		for (int i = 0; i < NUM_DIVIDERS; i++) begin
			cnt_p1[i] = cnt_q[i] + 1'b1;
			wrap[i]   = tick && (cnt_p1[i] >= DIV_PERIOD[i]);
			if (!tick) begin
				cnt_d[i] = cnt_q[i];
			end else if (wrap[i]) begin
				cnt_d[i] = '0;
			end else begin
				cnt_d[i] = cnt_p1[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIVIDERS; i++) begin
				cnt_q[i] <= DIV_START[i];
			end
		end else begin
			for (int i = 0; i < NUM_DIVIDERS; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

endmodule

[hw/rtl/mrtp_pending_bank.sv]
// mrtp_pending_bank: ten saturating pending counters with consume and readback.
// Depends on mrtp_pkg; takes the divider wrap flags from mrtp_divider_bank.
module mrtp_pending_bank import mrtp_pkg::*; #(
	parameter int PENDING_WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mrtp_cmd_t               cmd,
	input  logic [NUM_DIVIDERS-1:0] wrap,
	input  logic [LIMIT_WIDTH-1:0]  limit,
	output logic                    granted,
	output logic [RESULT_WIDTH-1:0] pending_after
);

	localparam int CW = (PENDING_WIDTH > LIMIT_WIDTH) ? PENDING_WIDTH : LIMIT_WIDTH;
	localparam logic [CW-1:0] PEND_MAX = CW'((1 << PENDING_WIDTH) - 1);

	logic [PENDING_WIDTH-1:0] cnt_q [NUM_PENDING];
	logic [PENDING_WIDTH-1:0] cnt_d [NUM_PENDING];
	logic [NUM_PENDING-1:0]   bump;
	logic [CW-1:0]            ceil;
	logic [CW-1:0]            limit_ext;
	logic [CW-1:0]            after_ext;
	logic                     in_range;
	logic [SEL_WIDTH-1:0]     sel_idx;

	assign limit_ext = CW'(limit);
	assign ceil      = (limit_ext > PEND_MAX) ? PEND_MAX : limit_ext;
	assign bump      = {wrap & {NUM_DIVIDERS{cmd.tick}}, cmd.tick};

	always_comb begin
		for (int i = 0; i < NUM_PENDING; i++) begin
			cnt_d[i] = cnt_q[i];
			if (bump[i] && (CW'(cnt_q[i]) < ceil)) begin
				cnt_d[i] = cnt_q[i] + 1'b1;
			end else if (cmd.consume && (cmd.sel == SEL_WIDTH'(i)) && (cnt_q[i] != '0)) begin
				cnt_d[i] = cnt_q[i] - 1'b1;
			end
		end
	end

	assign in_range      = cmd.sel < SEL_WIDTH'(NUM_PENDING);
	assign sel_idx       = in_range ? cmd.sel : '0;
	assign granted       = cmd.consume && in_range && (cnt_q[sel_idx] != '0);
	assign after_ext     = CW'(cnt_d[sel_idx]);
	assign pending_after = in_range ? after_ext[RESULT_WIDTH-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PENDING; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_PENDING; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

endmodule

[hw/rtl/multi_rate_tick_pending_counters.sv]
// multi_rate_tick_pending_counters: top level of the periodic task pending counters.
// Depends on mrtp_pkg, mrtp_if, mrtp_divider_bank and mrtp_pending_bank.
//
//  channel | dir | fields                         | handshake
//  --------+-----+--------------------------------+-------------------------------
//  req     | in  | opcode, period_select          | valid/ready
//  rsp     | out | granted, pending_after         | valid/ready
//  apb     | in  | pending_limit at byte addr 0   | psel/penable/pwrite, pready=1
//
// One word per cycle while req.ready is high: a word is accepted, state is updated
// at that edge and the result lands in the response register at that same edge.
// req.ready drops only while the response register is full and rsp.ready is low,
// so a held result and a new request overlap whenever the sink keeps up.
// arst_n clears the dividers to their phase offsets, all pending counts to zero
// and pending_limit to 255.
module multi_rate_tick_pending_counters import mrtp_pkg::*; #(
	parameter int PENDING_WIDTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	mrtp_req_if.sink                  req,
	mrtp_rsp_if.source                rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready
);

	logic [LIMIT_WIDTH-1:0]  limit_q;
	logic                    rsp_valid_q;
	logic                    granted_q;
	logic [RESULT_WIDTH-1:0] pending_after_q;
	logic                    accept;
	mrtp_cmd_t               cmd;
	logic [NUM_DIVIDERS-1:0] wrap;
	logic                    granted;
	logic [RESULT_WIDTH-1:0] pending_after;
	reg_idx_t                reg_idx;

	// ---------------- config port ----------------
	// register index is the word address; only index 0 is mapped
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign prdata  = (reg_idx == REG_PENDING_LIMIT) ? APB_DATA_WIDTH'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_PENDING_LIMIT)) begin
			limit_q <= pwdata[LIMIT_WIDTH-1:0];
		end
	end

	// ---------------- request decode ----------------
	// response register frees up in the same cycle it is drained
	assign req.ready   = !rsp_valid_q || rsp.ready;
	assign accept      = req.valid && req.ready;
	assign cmd.tick    = accept && (opcode_t'(req.opcode) == OP_TICK);
	assign cmd.consume = accept && (opcode_t'(req.opcode) == OP_CONSUME);
	assign cmd.sel     = req.period_select;

	mrtp_divider_bank u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (cmd.tick),
		.wrap   (wrap)
	);

	mrtp_pending_bank #(
		.PENDING_WIDTH (PENDING_WIDTH)
	) u_pend (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wrap          (wrap),
		.limit         (limit_q),
		.granted       (granted),
		.pending_after (pending_after)
	);

	// ---------------- response register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			granted_q       <= granted;
			pending_after_q <= pending_after;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.granted       = granted_q;
	assign rsp.pending_after = pending_after_q;

endmodule

[hw/rtl/mrtp_checker.sv]
// mrtp_checker: port-level assertions for multi_rate_tick_pending_counters.
// Depends on mrtp_pkg; bound to the top level below.
module mrtp_checker import mrtp_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    req_opcode,
	input logic [SEL_WIDTH-1:0]    req_period_select,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic                    rsp_granted,
	input logic [RESULT_WIDTH-1:0] rsp_pending_after
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// every accepted request shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("no result after accepted request");

	// ticks never grant
	a_tick_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (opcode_t'(req_opcode) == OP_TICK) |=> !rsp_granted)
		else $error("tick reported a grant");

	// unmapped selector reports nothing
	a_bad_sel: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_period_select >= SEL_WIDTH'(NUM_PENDING))
		|=> !rsp_granted && (rsp_pending_after == '0))
		else $error("unmapped selector gave a result");

	// a held result does not change while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready
		|=> rsp_valid && $stable(rsp_granted) && $stable(rsp_pending_after))
		else $error("stalled result changed");

endmodule

bind multi_rate_tick_pending_counters mrtp_checker u_mrtp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_opcode        (req.opcode),
	.req_period_select (req.period_select),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_granted       (rsp.granted),
	.rsp_pending_after (rsp.pending_after)
);

[tb/sv/mrtp_tb_pkg.sv]
// mrtp_tb_pkg: scoreboard for the multi-rate tick pending counters testbench.
// Depends on mrtp_pkg; the class mirrors the dividers and pending counts.
package mrtp_tb_pkg;
	import mrtp_pkg::*;

	localparam int PEND_W = 8;

	typedef struct {
		logic                    granted;
		logic [RESULT_WIDTH-1:0] pending_after;
	} pend_result_t;

	class pending_count_board;
		logic [LIMIT_WIDTH-1:0] limit;
		div_cnt_t               div_count [NUM_DIVIDERS];
		logic [PEND_W-1:0]      pend [NUM_PENDING];
		pend_result_t           expected_q [$];
		int                     errors;

		function new();
			limit = LIMIT_RESET;
			foreach (div_count[i]) div_count[i] = DIV_START[i];
			foreach (pend[i]) pend[i] = '0;
			errors = 0;
		endfunction

		function void set_limit(logic [LIMIT_WIDTH-1:0] v);
			limit = v;
		endfunction

		// saturating increment; ceiling is the limit clipped to the count width
		function void bump(int idx);
			int unsigned ceiling;
			ceiling = limit;
			if (ceiling > (1 << PEND_W) - 1)
				ceiling = (1 << PEND_W) - 1;
			if (pend[idx] < ceiling)
				pend[idx] = pend[idx] + 1'b1;
		endfunction

		// an accepted request word: advance the state, queue its result
		function void note_word(opcode_t op, logic [SEL_WIDTH-1:0] sel);
			pend_result_t r;
			div_cnt_t     nxt;
			r.granted = 1'b0;
			if (op == OP_TICK) begin
				bump(0);
				for (int i = 0; i < NUM_DIVIDERS; i++) begin
					nxt = div_count[i] + 1'b1;
					if (nxt >= DIV_PERIOD[i]) begin
						nxt = '0;
						bump(i + 1);
					end
					div_count[i] = nxt;
				end
			end else if (sel < NUM_PENDING) begin
				if (pend[sel] != '0) begin
					pend[sel] = pend[sel] - 1'b1;
					r.granted = 1'b1;
				end
			end
			r.pending_after = (sel < NUM_PENDING) ? pend[sel] : '0;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic granted, logic [RESULT_WIDTH-1:0] pending_after);
			pend_result_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: response word with none outstanding: granted %0d pending_after %0d",
					$time, granted, pending_after);
				errors++;
			end else begin
				r = expected_q.pop_front();
				if (granted !== r.granted) begin
					$display("%0t: granted mismatch, expected %0d, actual %0d",
						$time, r.granted, granted);
					errors++;
				end
				if (pending_after !== r.pending_after) begin
					$display("%0t: pending_after mismatch, expected %0d, actual %0d",
						$time, r.pending_after, pending_after);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

endpackage

[tb/sv/multi_rate_tick_pending_counters_tb.sv]
// multi_rate_tick_pending_counters_tb: drives ticks and consumes, checks every response word.
// Depends on mrtp_pkg, mrtp_if, mrtp_tb_pkg and the multi_rate_tick_pending_counters RTL.
module multi_rate_tick_pending_counters_tb;
	import mrtp_pkg::*;
	import mrtp_tb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 300;       // long response stall for back-pressure
	localparam int RUN_LIMIT_NS = 2_000_000; // far beyond the slowest legal run

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_WIDTH-1:0] pwdata;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;

	mrtp_req_if req_ch ();
	mrtp_rsp_if rsp_ch ();

	multi_rate_tick_pending_counters dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pending_count_board board = new();

	// idle percentages, changed per phase by the main sequence
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	// each increment asks the response side for one long hold-off
	int hold_req_seq      = 0;

	always #5 clk = ~clk;

	// every input known from time zero
	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.opcode  <= OP_TICK;
		req_ch.period_select <= '0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("multi_rate_tick_pending_counters_tb NOT OK");
		$finish;
	end

	// response side: random ready, plus a counted hold-off on request
	initial begin : response_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_seen != hold_req_seq) begin
				hold_seen = hold_req_seq;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// response monitor; values sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.check_result(rsp_ch.granted, rsp_ch.pending_after);
	end

	// APB write: setup then access; register takes it when pready is seen high
	task automatic apb_write(reg_idx_t idx, logic [LIMIT_WIDTH-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {(APB_DATA_WIDTH - LIMIT_WIDTH)'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_PENDING_LIMIT)
			board.set_limit(v);
	endtask

	// offer one request word; valid stays high into the next word unless a gap is drawn
	task automatic send_word(opcode_t op, logic [SEL_WIDTH-1:0] sel);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.opcode        <= op;
		req_ch.period_select <= sel;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		board.note_word(op, sel);
	endtask

	// stop offering and wait until every response word has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// random traffic in chunks: mixed words, tick bursts that push counts to the ceiling,
	// and consume bursts on one selector that drain a counter past zero
	task automatic random_words(int n, int tick_pct);
		int                   left;
		int                   len;
		int                   mode;
		logic [SEL_WIDTH-1:0] sel;
		opcode_t              op;
		left = n;
		while (left > 0) begin
			mode = $urandom_range(5);
			len  = (mode == 0) ? $urandom_range(60, 10) :
			       (mode == 1) ? $urandom_range(30, 5) : $urandom_range(40, 5);
			if (len > left)
				len = left;
			sel = ($urandom_range(5) == 0) ? SEL_WIDTH'($urandom_range(15)) :
			      SEL_WIDTH'($urandom_range(NUM_PENDING - 1));
			for (int i = 0; i < len; i++) begin
				if (mode == 0) begin
					op = OP_TICK;
					sel = SEL_WIDTH'($urandom_range(15));
				end else if (mode == 1) begin
					op = OP_CONSUME;
				end else begin
					op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_CONSUME;
					// mostly valid selectors, some out of range
					sel = ($urandom_range(7) == 0) ? SEL_WIDTH'($urandom_range(15)) :
					      SEL_WIDTH'($urandom_range(NUM_PENDING - 1));
				end
				send_word(op, sel);
			end
			left -= len;
		end
	endtask

	initial begin : main_seq
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write(REG_PENDING_LIMIT, 8'd255);

		// directed: empty consumes, out-of-range selectors, first divider wraps
		send_word(OP_CONSUME, 4'd0);  // nothing pending yet
		send_word(OP_CONSUME, 4'd9);
		send_word(OP_CONSUME, 4'd15); // selector out of range
		send_word(OP_TICK,    4'd15); // tick reporting an out-of-range selector
		send_word(OP_TICK,    4'd1);  // 2 ms and 5 ms dividers wrap here
		send_word(OP_CONSUME, 4'd1);
		send_word(OP_CONSUME, 4'd2);
		send_word(OP_CONSUME, 4'd0);
		send_word(OP_CONSUME, 4'd0);
		send_word(OP_CONSUME, 4'd0);  // drained past zero
		send_word(OP_CONSUME, 4'd10);
		for (int i = 0; i < 8; i++)
			send_word(OP_TICK, i[SEL_WIDTH-1:0]);
		for (int i = 3; i < NUM_PENDING; i++)
			send_word(OP_CONSUME, i[SEL_WIDTH-1:0]);

		// sender idles now and then, receiver mostly stalls
		sender_idle_pct   = 19;
		receiver_idle_pct = 80;
		random_words(550, 70);

		// unmapped address must not disturb the limit; then drop the limit below the counts
		drain();
		apb_write(REG_UNMAPPED, 8'($urandom));
		apb_write(REG_PENDING_LIMIT, 8'd2);
		sender_idle_pct   = 80;
		receiver_idle_pct = 19;
		random_words(500, 45);

		// zero limit: nothing may increment
		drain();
		apb_write(REG_PENDING_LIMIT, 8'd0);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		send_word(OP_TICK, 4'd0);
		send_word(OP_CONSUME, 4'd0);
		random_words(150, 60);

		// back-pressure: long response hold-off while requests keep coming
		drain();
		apb_write(REG_PENDING_LIMIT, 8'd255);
		hold_req_seq++;
		random_words(40, 80);
		// sender pauses until every result is back
		drain();
		apb_write(REG_PENDING_LIMIT, 8'd128);
		random_words(500, 55);

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("multi_rate_tick_pending_counters_tb OK");
		end else begin
			$display("multi_rate_tick_pending_counters_tb NOT OK");
		end
		$finish;
	end

endmodule
